// File: hw/rtl/ssp_pkg.sv
// Shared types, character codes and decode helpers for the size suffix string parser.
`timescale 1ns / 1ps

package ssp_pkg;

  // Width of the decoded size
  localparam int unsigned SizeW = 64;

  // Character codes
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChKilo   = 8'h4B;  // K
  localparam logic [7:0] ChMega   = 8'h4D;  // M
  localparam logic [7:0] ChGiga   = 8'h47;  // G
  localparam logic [7:0] ChTera   = 8'h54;  // T
  localparam logic [7:0] ChPeta   = 8'h50;  // P
  localparam logic [7:0] ChExa    = 8'h45;  // E
  localparam logic [7:0] ChBitLo  = 8'h62;  // b
  localparam logic [7:0] ChByteUp = 8'h42;  // B

  // Shift applied by a B suffix (eight bits per byte)
  localparam logic [5:0] ByteShift = 6'd3;

  // Parse phase
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_DIGIT = 3'd1,
    PH_MULT  = 3'd2,
    PH_BIT   = 3'd3,
    PH_TRAIL = 3'd4,
    PH_FAIL  = 3'd5
  } phase_e;

  // Input beat
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } ssp_in_t;

  // Result beat
  typedef struct packed {
    logic             ok;
    logic [SizeW-1:0] size_bits;
  } ssp_out_t;

  // Result handed from the step logic to the output register
  typedef struct packed {
    logic     valid;
    ssp_out_t data;
  } ssp_res_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == ChSpace) || (c inside {[ChTab:ChCr]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[ChZero:ChNine]};
  endfunction

  // Power-of-1024 letter to shift amount, zero when not such a letter
  function automatic logic [5:0] pow_shift(input logic [7:0] c);
    logic [5:0] sh;
    case (c)
      ChKilo:  sh = 6'd10;
      ChMega:  sh = 6'd20;
      ChGiga:  sh = 6'd30;
      ChTera:  sh = 6'd40;
      ChPeta:  sh = 6'd50;
      ChExa:   sh = 6'd60;
      default: sh = 6'd0;
    endcase
    return sh;
  endfunction

endpackage

// File: hw/rtl/ssp_in_reg.sv
// Input register: captures one character beat and holds it until the step logic takes it.
`timescale 1ns / 1ps

module ssp_in_reg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ssp_pkg::ssp_in_t in_data_i,
  input  logic            take_i,
  output logic            valid_o,
  output ssp_pkg::ssp_in_t data_o
);

  logic             valid_q;
  ssp_pkg::ssp_in_t data_q;
  logic             load;

  // Stall only while a held beat is not taken this cycle
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  // Track occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: hw/rtl/ssp_step.sv
// Step logic: phase and accumulator update for one character, result on the last beat.
`timescale 1ns / 1ps

module ssp_step (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  ssp_pkg::ssp_in_t  data_i,
  input  logic              out_free_i,
  output logic              take_o,
  output ssp_pkg::ssp_res_t res_o
);

  ssp_pkg::phase_e              phase_q, phase_d;
  logic [ssp_pkg::SizeW-1:0]    acc_q, acc_d;
  logic [ssp_pkg::SizeW-1:0]    digit;
  logic [5:0]                   sh;
  logic [7:0]                   c;
  logic                         ok;

  assign c     = data_i.character;
  assign digit = {{(ssp_pkg::SizeW-4){1'b0}}, c[3:0]};
  assign sh    = ssp_pkg::pow_shift(c);

  // A beat that ends a string needs room in the output register
  assign take_o = valid_i && (!data_i.last || out_free_i);

  // Next phase and accumulator
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    case (phase_q)
      ssp_pkg::PH_LEAD: begin
        if (ssp_pkg::is_ws(c)) begin
          phase_d = ssp_pkg::PH_LEAD;
        end else if (ssp_pkg::is_digit(c)) begin
          acc_d   = digit;
          phase_d = ssp_pkg::PH_DIGIT;
        end else begin
          phase_d = ssp_pkg::PH_FAIL;
        end
      end
      ssp_pkg::PH_DIGIT, ssp_pkg::PH_MULT: begin
        if ((phase_q == ssp_pkg::PH_DIGIT) && ssp_pkg::is_digit(c)) begin
          // value*10 + digit, wrapping
          acc_d = (acc_q << 3) + (acc_q << 1) + digit;
        end else if ((phase_q == ssp_pkg::PH_DIGIT) && (sh != 6'd0)) begin
          acc_d   = acc_q << sh;
          phase_d = ssp_pkg::PH_MULT;
        end else if (c == ssp_pkg::ChBitLo) begin
          phase_d = ssp_pkg::PH_BIT;
        end else if (c == ssp_pkg::ChByteUp) begin
          acc_d   = acc_q << ssp_pkg::ByteShift;
          phase_d = ssp_pkg::PH_BIT;
        end else if (ssp_pkg::is_ws(c)) begin
          phase_d = ssp_pkg::PH_TRAIL;
        end else begin
          phase_d = ssp_pkg::PH_FAIL;
        end
      end
      ssp_pkg::PH_BIT, ssp_pkg::PH_TRAIL: begin
        phase_d = ssp_pkg::is_ws(c) ? ssp_pkg::PH_TRAIL : ssp_pkg::PH_FAIL;
      end
      default: begin
        phase_d = ssp_pkg::PH_FAIL;
      end
    endcase
  end

  // Valid once a digit was seen and nothing failed
  assign ok = phase_d inside {ssp_pkg::PH_DIGIT, ssp_pkg::PH_MULT,
                              ssp_pkg::PH_BIT, ssp_pkg::PH_TRAIL};

  assign res_o.valid          = take_o && data_i.last;
  assign res_o.data.ok        = ok;
  assign res_o.data.size_bits = ok ? acc_d : '0;

  // Advance state; rearm after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ssp_pkg::PH_LEAD;
      acc_q   <= '0;
    end else if (take_o) begin
      if (data_i.last) begin
        phase_q <= ssp_pkg::PH_LEAD;
        acc_q   <= '0;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
      end
    end
  end

endmodule

// File: hw/rtl/ssp_out_reg.sv
// Output register: holds one result beat until the receiver takes it.
`timescale 1ns / 1ps

module ssp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssp_pkg::ssp_res_t res_i,
  output logic              out_free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ssp_pkg::ssp_out_t out_data_o
);

  logic              valid_q;
  ssp_pkg::ssp_out_t data_q;

  // Room when empty or drained this cycle
  assign out_free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_i.valid) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  // Load a new result beat
  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      data_q <= res_i.data;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: hw/rtl/size_suffix_string_parser.sv
// Top level of the size suffix string parser.
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+-------------------------------
//   in      | input     | in_valid_i/in_stall_o | character, last
//   out     | output    | out_valid_o/out_stall_i | ok, size_bits (one per string)
//
// One character is taken every cycle unless the input stalls. A beat waits in the
// input register while its step (digit accumulate, suffix shift) is computed; as
// it is taken the step updates its state, or a last beat loads the output register.
// Reset returns the parser to the leading whitespace phase with a zero accumulator.
// An output stall holds the result; the input stalls only when a last character
// meets an output register still full.
`timescale 1ns / 1ps

module size_suffix_string_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ssp_pkg::ssp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ssp_pkg::ssp_out_t out_data_o
);

  logic              beat_valid;
  ssp_pkg::ssp_in_t  beat_data;
  logic              take;
  logic              out_free;
  ssp_pkg::ssp_res_t res;

  ssp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .valid_o    (beat_valid),
    .data_o     (beat_data)
  );

  ssp_step u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (beat_valid),
    .data_i     (beat_data),
    .out_free_i (out_free),
    .take_o     (take),
    .res_o      (res)
  );

  ssp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/ssp_checker.sv
// Port-level checker for the size suffix string parser, with its bind.
`timescale 1ns / 1ps

module ssp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input ssp_pkg::ssp_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input ssp_pkg::ssp_out_t out_data_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // Failed strings report zero size
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.size_bits == '0)
    else $error("failed result with nonzero size");

  // Input never stalls while the output drains freely
  a_no_stall_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled with output not stalled");

  // Input stalls only behind a pending result
  a_stall_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind size_suffix_string_parser ssp_checker u_ssp_checker (.*);
